// ----- hw/rtl/str2u_pkg.sv -----
// ----------------------------------------------------------------------------
// str2u_pkg: shared types and constants for the string to unsigned parser
// Holds the parser phases, the classified character record that travels from
// the front end to the back end, and the character codes used for decoding.
// ----------------------------------------------------------------------------
package str2u_pkg;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_WS     = 3'd1,
      PH_SIGN   = 3'd2,
      PH_ZERO   = 3'd3,
      PH_HEX    = 3'd4,
      PH_DIGITS = 3'd5
   } phase_type;

   // One classified character as it waits in the queue.
   typedef struct packed {
      logic       first;
      logic       is_space;
      logic       is_minus;
      logic       is_plus;
      logic       is_zero;
      logic       is_x;
      logic [5:0] digit;
   } item_type;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned RADIX_W    = 6;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned OFFSET_W   = 12;
   localparam int unsigned PROD_W     = VALUE_W + RADIX_W;
   localparam int unsigned RSP_DATA_W = 80;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   // Digit code for a character that is no digit in any base.
   localparam logic [5:0] DIGIT_NONE = 6'd63;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

   // Letter offsets: 'A' - 10 and 'a' - 10.
   localparam logic [CHAR_W-1:0] UC_BIAS = 8'h37;
   localparam logic [CHAR_W-1:0] LC_BIAS = 8'h57;

endpackage

// ----- hw/rtl/str2u_front.sv -----
// ----------------------------------------------------------------------------
// str2u_front: character classifier
// Decodes one input character into the flags and digit value that the back
// end needs, so that the back end works on a compact record.
// ----------------------------------------------------------------------------
module str2u_front (
   input  logic [str2u_pkg::CHAR_W-1:0] ch,
   input  logic                         first,
   output str2u_pkg::item_type          item
);

   logic [str2u_pkg::CHAR_W-1:0] diff;

   // Character class flags, then the digit value: decimal digits, then letters
   // in either case.
   always_comb begin
      diff          = '0;
      item.first    = first;
      item.is_space = (ch == str2u_pkg::CH_SPACE) ||
                      (ch >= str2u_pkg::CH_TAB && ch <= str2u_pkg::CH_CR);
      item.is_minus = (ch == str2u_pkg::CH_MINUS);
      item.is_plus  = (ch == str2u_pkg::CH_PLUS);
      item.is_zero  = (ch == str2u_pkg::CH_ZERO);
      item.is_x     = (ch == str2u_pkg::CH_LC_X) || (ch == str2u_pkg::CH_UC_X);
      item.digit    = str2u_pkg::DIGIT_NONE;
      if (ch >= str2u_pkg::CH_ZERO && ch <= str2u_pkg::CH_NINE) begin
         diff = ch - str2u_pkg::CH_ZERO;
         item.digit = diff[5:0];
      end else if (ch >= str2u_pkg::CH_LC_A && ch <= str2u_pkg::CH_LC_Z) begin
         diff = ch - str2u_pkg::LC_BIAS;
         item.digit = diff[5:0];
      end else if (ch >= str2u_pkg::CH_UC_A && ch <= str2u_pkg::CH_UC_Z) begin
         diff = ch - str2u_pkg::UC_BIAS;
         item.digit = diff[5:0];
      end
   end

endmodule

// ----- hw/rtl/str2u_queue.sv -----
// ----------------------------------------------------------------------------
// str2u_queue: two-entry queue of classified characters
// Decouples the input side from the parser so that each may stall on its own.
// A push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module str2u_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  str2u_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output str2u_pkg::item_type head
);

   str2u_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/str2u_back.sv -----
// ----------------------------------------------------------------------------
// str2u_back: parser state machine, accumulator and result register
// Takes one classified character a cycle while the result register can
// accept a beat, steps the phase machine through whitespace, sign, prefix
// and digits, and loads a result beat when the string ends.
// ----------------------------------------------------------------------------
module str2u_back #(
   parameter int unsigned MAX_LEN = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [str2u_pkg::RADIX_W-1:0]       radix,
   input  logic                                item_valid,
   input  str2u_pkg::item_type                 item,
   output logic                                item_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [str2u_pkg::RSP_DATA_W-1:0]    rsp_data
);

   localparam int unsigned POS_W = $clog2(MAX_LEN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEN - 1);

   str2u_pkg::phase_type phase_ff, phase_in, ph_e;
   logic [str2u_pkg::VALUE_W-1:0] acc_ff, acc_in, acc_e;
   logic minus_ff, minus_in, minus_e;
   logic ovf_ff, ovf_in, ovf_e;
   logic dseen_ff, dseen_in, dseen_e;
   logic [str2u_pkg::RADIX_W-1:0] ar_ff, ar_in, ar_e, ar_dig;
   logic [POS_W-1:0] pos_ff, pos_in, pos_e;

   logic rsp_valid_ff, rsp_valid_in;
   logic [str2u_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic go, live, bad_radix, sign_here, zero_path, digits_here, digit_ok;
   logic emit, emit_hex, emit_at_pos;
   logic [str2u_pkg::PROD_W-1:0] prod;
   logic [str2u_pkg::VALUE_W-1:0] value;
   logic [POS_W-1:0] end_pos;
   logic [POS_W+str2u_pkg::OFFSET_W-1:0] end_wide;
   logic [str2u_pkg::OFFSET_W-1:0] end_offset;

   // A character is taken whenever the result register can accept a beat.
   assign go       = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_pop = go;

   // State as seen by this character: a new string restarts everything.
   always_comb begin
      if (item.first) begin
         ph_e    = str2u_pkg::PH_WS;
         acc_e   = '0;
         minus_e = 1'b0;
         ovf_e   = 1'b0;
         dseen_e = 1'b0;
         ar_e    = radix;
         pos_e   = '0;
      end else begin
         ph_e    = phase_ff;
         acc_e   = acc_ff;
         minus_e = minus_ff;
         ovf_e   = ovf_ff;
         dseen_e = dseen_ff;
         ar_e    = ar_ff;
         pos_e   = (pos_ff < POS_LAST) ? pos_ff + 1'b1 : pos_ff;
      end
      live = item.first || (phase_ff != str2u_pkg::PH_IDLE);
   end

   // Phase decode, including fall-through from one phase to the next.
   always_comb begin
      bad_radix = (ar_e == str2u_pkg::RADIX_ONE) || (ar_e > str2u_pkg::RADIX_MAX);
      sign_here = (ph_e == str2u_pkg::PH_SIGN) ||
                  ((ph_e == str2u_pkg::PH_WS) && !item.is_space &&
                   !item.is_minus && !item.is_plus);
      zero_path = sign_here && !bad_radix && item.is_zero &&
                  ((ar_e == str2u_pkg::RADIX_AUTO) || (ar_e == str2u_pkg::RADIX_HEX));
      digits_here = (ph_e == str2u_pkg::PH_DIGITS) ||
                    (sign_here && !bad_radix && !zero_path) ||
                    ((ph_e == str2u_pkg::PH_ZERO) && !item.is_x) ||
                    ((ph_e == str2u_pkg::PH_HEX) && (item.digit < str2u_pkg::RADIX_HEX));
      if (ar_e == str2u_pkg::RADIX_AUTO) begin
         ar_dig = (ph_e == str2u_pkg::PH_ZERO) ? str2u_pkg::RADIX_OCT
                                                : str2u_pkg::RADIX_DEC;
      end else begin
         ar_dig = ar_e;
      end
      digit_ok    = digits_here && (item.digit < ar_dig);
      emit_hex    = (ph_e == str2u_pkg::PH_HEX) && (item.digit >= str2u_pkg::RADIX_HEX);
      emit_at_pos = digits_here && !digit_ok;
      emit        = live && ((sign_here && bad_radix) || emit_hex || emit_at_pos);
      prod = str2u_pkg::PROD_W'(acc_e) * str2u_pkg::PROD_W'(ar_dig) +
             str2u_pkg::PROD_W'(item.digit);
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      minus_in = minus_ff;
      ovf_in   = ovf_ff;
      dseen_in = dseen_ff;
      ar_in    = ar_ff;
      pos_in   = pos_ff;
      if (go && live) begin
         acc_in   = acc_e;
         minus_in = minus_e;
         ovf_in   = ovf_e;
         dseen_in = dseen_e;
         ar_in    = ar_e;
         pos_in   = pos_e;
         if (emit) begin
            phase_in = str2u_pkg::PH_IDLE;
         end else if (ph_e == str2u_pkg::PH_WS && item.is_space) begin
            phase_in = str2u_pkg::PH_WS;
         end else if (ph_e == str2u_pkg::PH_WS && (item.is_minus || item.is_plus)) begin
            phase_in = str2u_pkg::PH_SIGN;
            minus_in = item.is_minus;
         end else if (zero_path) begin
            phase_in = str2u_pkg::PH_ZERO;
            dseen_in = 1'b1;
         end else if (ph_e == str2u_pkg::PH_ZERO && item.is_x) begin
            phase_in = str2u_pkg::PH_HEX;
            ar_in    = str2u_pkg::RADIX_HEX;
         end else begin
            // A digit below the base: multiply-add, saturating on overflow.
            phase_in = str2u_pkg::PH_DIGITS;
            ar_in    = ar_dig;
            dseen_in = 1'b1;
            if (ovf_e || (prod[str2u_pkg::PROD_W-1:str2u_pkg::VALUE_W] != '0)) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = prod[str2u_pkg::VALUE_W-1:0];
            end
         end
      end
   end

   // Result beat contents.
   always_comb begin
      if (ovf_e) begin
         value = '1;
      end else if (minus_e) begin
         value = '0 - acc_e;
      end else begin
         value = acc_e;
      end
      end_pos    = emit_hex ? pos_e - 1'b1 : pos_e;
      end_wide   = {{str2u_pkg::OFFSET_W{1'b0}}, end_pos};
      end_offset = dseen_e ? end_wide[str2u_pkg::OFFSET_W-1:0] : '0;
      rsp_data_in = {2'b00, end_offset, dseen_e, ovf_e, value};
      if (go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= str2u_pkg::PH_IDLE;
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         dseen_ff     <= 1'b0;
         ar_ff        <= str2u_pkg::RADIX_RESET;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         minus_ff     <= minus_in;
         ovf_ff       <= ovf_in;
         dseen_ff     <= dseen_in;
         ar_ff        <= ar_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (go && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/string_to_unsigned_parser_top.sv -----
// A terminating beat is queued, then its result is registered. Throughput: one character
// beat per cycle while the output does not stall, set by the single multiply-add in the
// parser. A two-entry queue lets the input side keep going for two beats while the output
// stalls. Reset (synchronous, active high) empties the queue and result register, sets the
// base register to ten and leaves the parser idle until a beat marked as a string start.
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_top: streaming string to unsigned 64-bit parser
// Parses one character per beat with whitespace, sign and base-prefix
// handling, and returns one result beat per string.
// ----------------------------------------------------------------------------
module string_to_unsigned_parser_top #(
   parameter int unsigned MAX_LEN = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // Input beats.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [0:0]  req_tuser,   // [0] first
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [63:0] value, [64] overflowed, [65] converted,
                                    // [77:66] end_offset, [79:78] zero
   // Base register.
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   logic [str2u_pkg::RADIX_W-1:0] radix_ff, radix_in;
   str2u_pkg::item_type front_item, head_item;
   logic q_full, q_not_empty, q_pop, q_push;

   // Base register.
   assign radix_in = csr_wr_en ? csr_wr_data : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= str2u_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Front end: classify and queue each accepted beat.
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   str2u_front u_front (
      .ch    (req_tdata),
      .first (req_tuser[0]),
      .item  (front_item)
   );

   str2u_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_item)
   );

   // Back end: parse and hold the result beat.
   str2u_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .radix      (radix_ff),
      .item_valid (q_not_empty),
      .item       (head_item),
      .item_pop   (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

endmodule
